// ----- hdl/pshc_pkg.sv -----
package pshc_pkg;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned POS_SAT = 32;
  localparam int unsigned WIN_LEN = 8;

  typedef enum logic [2:0] {
    FAIL_NONE  = 3'd0,
    FAIL_SIG   = 3'd1,
    FAIL_IHDR  = 3'd2,
    FAIL_TRAIL = 3'd3,
    FAIL_SHORT = 3'd4
  } fail_t;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
  };

  localparam logic [7:0] IHDR_BYTES [4] = '{8'd73, 8'd72, 8'd68, 8'd82};

  localparam logic [7:0] IEND_BYTES [WIN_LEN] = '{
    8'd73, 8'd69, 8'd78, 8'd68, 8'd174, 8'd66, 8'd96, 8'd130
  };

  // One finished check result, as it travels from the parser to the output register.
  typedef struct packed {
    logic        valid_res;
    fail_t       fail_reason;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

endpackage

// ----- hdl/png_stream_header_checker.sv -----
// Path: a byte accepted into the input register is parsed from there; a result caused by a
// final byte passes the input register and then the result register to reach the out_ ports.
// Throughput: one byte per cycle, sustained, set by the single parse stage between the
// input register and the result register; only a held result stalls a final byte.
// Reset: synchronous, active-low rst_n clears both request registers and all parse state.
module png_stream_header_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [2:0]  out_fail_reason,
  output logic [31:0] out_width,
  output logic [31:0] out_height
);

  // Input register: holds one byte request until the parse stage takes it.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Result register: holds one finished result until the consumer takes it.
  logic              out_vld_r;
  pshc_pkg::result_t out_res_r;

  pshc_pkg::result_t res;
  logic              step;
  logic              out_free;

  // The result register can take a new result when it is empty or being drained.
  assign out_free = !out_vld_r || out_ready;

  // A byte that is not the final one produces no result, so it never waits on the output.
  assign step = in_vld_r && (!in_last_r || out_free);

  assign in_ready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last;
    end
  end

  pshc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last      (in_last_r),
    .res       (res)
  );

  // A final byte loads the result register; otherwise a taken result empties it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_valid_res   = out_res_r.valid_res;
  assign out_fail_reason = out_res_r.fail_reason;
  assign out_width       = out_res_r.width;
  assign out_height      = out_res_r.height;

endmodule

// ----- hdl/pshc_parse.sv -----
module pshc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output pshc_pkg::result_t res
);

  logic [pshc_pkg::POS_W-1:0] pos_r, pos_nxt;
  pshc_pkg::fail_t            fail_r, fail_nxt;
  logic [31:0]                width_r, width_nxt;
  logic [31:0]                height_r, height_nxt;
  logic [7:0]                 win_r   [pshc_pkg::WIN_LEN];
  logic [7:0]                 win_nxt [pshc_pkg::WIN_LEN];

  logic            trail_ok;
  pshc_pkg::fail_t reason;

  always_comb begin
    pos_nxt    = pos_r;
    fail_nxt   = fail_r;
    width_nxt  = width_r;
    height_nxt = height_r;

    if (pos_r < 6'd8) begin
      if (data_byte != pshc_pkg::SIG_BYTES[pos_r[2:0]] && fail_r == pshc_pkg::FAIL_NONE) begin
        fail_nxt = pshc_pkg::FAIL_SIG;
      end
    end else if (pos_r inside {[6'd12:6'd15]}) begin
      if (data_byte != pshc_pkg::IHDR_BYTES[pos_r[1:0]] && fail_r == pshc_pkg::FAIL_NONE) begin
        fail_nxt = pshc_pkg::FAIL_IHDR;
      end
    end else if (pos_r inside {[6'd16:6'd19]}) begin
      width_nxt = {width_r[23:0], data_byte};
    end else if (pos_r inside {[6'd20:6'd23]}) begin
      height_nxt = {height_r[23:0], data_byte};
    end

    for (int i = 0; i < pshc_pkg::WIN_LEN - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[pshc_pkg::WIN_LEN-1] = data_byte;

    if (pos_r < pshc_pkg::POS_W'(pshc_pkg::POS_SAT)) begin
      pos_nxt = pos_r + 6'd1;
    end
  end

  always_comb begin
    trail_ok = 1'b1;
    for (int i = 0; i < pshc_pkg::WIN_LEN; i++) begin
      if (win_nxt[i] != pshc_pkg::IEND_BYTES[i]) begin
        trail_ok = 1'b0;
      end
    end

    reason = fail_nxt;
    if (fail_nxt == pshc_pkg::FAIL_NONE) begin
      if (pos_r < pshc_pkg::POS_W'(pshc_pkg::POS_SAT - 1)) begin
        reason = pshc_pkg::FAIL_SHORT;
      end else if (!trail_ok) begin
        reason = pshc_pkg::FAIL_TRAIL;
      end
    end

    res.valid_res   = (reason == pshc_pkg::FAIL_NONE);
    res.fail_reason = reason;
    res.width       = (reason == pshc_pkg::FAIL_NONE) ? width_nxt : 32'd0;
    res.height      = (reason == pshc_pkg::FAIL_NONE) ? height_nxt : 32'd0;
  end

  // The final byte of a file returns all state to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r    <= '0;
      fail_r   <= pshc_pkg::FAIL_NONE;
      width_r  <= '0;
      height_r <= '0;
      for (int i = 0; i < pshc_pkg::WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (step) begin
      pos_r    <= pos_nxt;
      fail_r   <= fail_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      win_r    <= win_nxt;
    end
  end

endmodule

// ----- hdl/pshc_checker.sv -----
module pshc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [2:0]  out_fail_reason,
  input logic [31:0] out_width,
  input logic [31:0] out_height
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fail_reason) && $stable(out_width))
    else $error("result request dropped or changed while stalled");

  a_pass_no_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_fail_reason == pshc_pkg::FAIL_NONE)
    else $error("passing file carries a failure reason");

  a_fail_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      (out_fail_reason == pshc_pkg::FAIL_SIG || out_fail_reason == pshc_pkg::FAIL_IHDR ||
       out_fail_reason == pshc_pkg::FAIL_TRAIL || out_fail_reason == pshc_pkg::FAIL_SHORT))
    else $error("failing file has no legal failure reason");

  a_fail_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_width == 32'd0 && out_height == 32'd0)
    else $error("failing file reports nonzero dimensions");

endmodule

bind png_stream_header_checker pshc_checker u_pshc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_valid_res   (out_valid_res),
  .out_fail_reason (out_fail_reason),
  .out_width       (out_width),
  .out_height      (out_height)
);
